// ----- rtl/ascm_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and types of the ascii cell mapper
package ascm_pkg;

  localparam int unsigned CELL_COUNT = 16384;
  localparam int unsigned CELL_W     = 14;
  localparam int unsigned TBL_AW     = 16;
  localparam int unsigned LVL_W      = 8;
  localparam int unsigned ENTRY_W    = 40;
  localparam int unsigned ERR_W      = 32;
  localparam int unsigned ERR_AW     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int unsigned CMP_W      = (CNT_W > CELL_W) ? CNT_W : CELL_W + 1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CONV = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DITHER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR   = 1'b1;

  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [7:0] LVL_MAX    = 8'hff;

  // four levels, element 3 is top-left, element 0 bottom-right
  typedef logic [3:0][LVL_W-1:0] lvl4_t;

  typedef struct packed {
    logic              en;
    logic [ERR_AW-1:0] addr;
    lvl4_t             data;
  } err_wr_t;

endpackage

// ----- rtl/ascm_err_store.sv -----
`timescale 1ns / 1ps
// per-cell error memory with post-reset clearing sweep
module ascm_err_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [ascm_pkg::ERR_AW-1:0] rd_addr_i,
  output ascm_pkg::lvl4_t        rd_data_o,
  input  ascm_pkg::err_wr_t      wr_i,
  output logic                   clearing_o
);
  import ascm_pkg::*;

  lvl4_t             mem [CELL_COUNT];
  lvl4_t             rd_q;
  logic              clr_busy_q, clr_busy_d;
  logic [ERR_AW-1:0] clr_addr_q, clr_addr_d;
  logic              we;
  logic [ERR_AW-1:0] waddr;
  lvl4_t             wdata;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ERR_AW'(1);
      if (clr_addr_q == ERR_AW'(CELL_COUNT - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clr_busy_q | wr_i.en;
  assign waddr = clr_busy_q ? clr_addr_q : wr_i.addr;
  assign wdata = clr_busy_q ? lvl4_t'('0) : wr_i.data;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clr_busy_q;

endmodule

// ----- rtl/ascm_glyph_table.sv -----
`timescale 1ns / 1ps
// glyph table memory: glyph code and four reproduced levels per entry
module ascm_glyph_table (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [ascm_pkg::TBL_AW-1:0]  wr_addr_i,
  input  logic [ascm_pkg::ENTRY_W-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [ascm_pkg::TBL_AW-1:0]  rd_addr_i,
  output logic [ascm_pkg::ENTRY_W-1:0] rd_data_o
);
  import ascm_pkg::*;

  logic [ENTRY_W-1:0] mem [2**TBL_AW];
  logic [ENTRY_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- rtl/ascm_quant.sv -----
`timescale 1ns / 1ps
// error add, clamp and table index forming for one cell
module ascm_quant (
  input  ascm_pkg::lvl4_t             pix_i,
  input  ascm_pkg::lvl4_t             err_i,
  input  logic                        apply_i,
  output ascm_pkg::lvl4_t             lvl_o,
  output logic [ascm_pkg::TBL_AW-1:0] idx_o
);
  import ascm_pkg::*;

  logic signed [LVL_W+1:0] sum [4];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      sum[p] = $signed({2'b00, pix_i[p]}) + $signed({{2{err_i[p][LVL_W-1]}}, err_i[p]});
      if (!apply_i) begin
        lvl_o[p] = pix_i[p];
      end else if (sum[p] < 0) begin
        lvl_o[p] = '0;
      end else if (sum[p] > $signed({2'b00, LVL_MAX})) begin
        lvl_o[p] = LVL_MAX;
      end else begin
        lvl_o[p] = sum[p][LVL_W-1:0];
      end
    end
    idx_o = {lvl_o[3][7:4], lvl_o[2][7:4], lvl_o[1][7:4], lvl_o[0][7:4]};
  end

endmodule

// ----- rtl/ascii_cell_mapper_with_temporal_dither_unit.sv -----
`timescale 1ns / 1ps
// top level of the ascii cell mapper with temporal dither
//
//  channel   direction  handshake            beat
//  in        sink       in_valid_i/ready_o   load entry or convert one cell
//  out       source     out_valid_o/ready_i  cell position and cell word
//  cfg       sink       cfg_we_i             dither enable, attribute byte
//
// one beat per cycle while the output does not stall; a convert beat's result
// passes the error read at acceptance and the table read, then sits in the
// output register
// after reset the error memory is swept to zero, one entry a cycle, over all
// CELL_COUNT entries (16384) with in_ready_o low; cfg writes still taken
// a stalled output holds the pipe only when its last stage is occupied;
// bubbles ahead of it still close up
// error read-modify-write of the same cell in adjacent beats is forwarded
module ascii_cell_mapper_with_temporal_dither_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ascm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ascm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [15:0]                     table_index_i,
  input  logic [7:0]                      glyph_code_i,
  input  logic [7:0]                      level_a_i,
  input  logic [7:0]                      level_b_i,
  input  logic [7:0]                      level_c_i,
  input  logic [7:0]                      level_d_i,
  input  logic [13:0]                     cell_index_i,
  input  logic [7:0]                      pixel_tl_i,
  input  logic [7:0]                      pixel_tr_i,
  input  logic [7:0]                      pixel_bl_i,
  input  logic [7:0]                      pixel_br_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [13:0]                     out_cell_o,
  output logic [15:0]                     cell_word_o
);
  import ascm_pkg::*;

  // configuration registers
  logic       dith_q;
  logic [7:0] attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dith_q <= 1'b0;
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DITHER: dith_q <= cfg_wdata_i[0];
        CFG_ATTR:   attr_q <= cfg_wdata_i[7:0];
        default:    ;
      endcase
    end
  end

  // pipeline control
  logic              clearing;
  logic              adv;
  logic              in_fire;
  logic              s1_valid_q, s2_valid_q;
  logic              s1_apply_q, s2_apply_q;
  logic [CELL_W-1:0] s1_cell_q, s2_cell_q;
  lvl4_t             s1_pix_q;
  lvl4_t             s2_lvl_q;
  logic              out_valid_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [15:0]       out_word_q;

  // last stage can move when it is empty or the output register frees up
  assign adv        = !s2_valid_q || !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !clearing;
  assign in_fire    = in_valid_i && in_ready_o;

  logic conv_fire;
  logic in_store;
  assign conv_fire = in_fire && (func_i == FUNC_CONV);
  assign in_store  = CMP_W'(cell_index_i) < CMP_W'(CELL_COUNT);

  // table load straight from the input beat
  logic               tbl_we;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [ENTRY_W-1:0] tbl_rdata;
  logic [TBL_AW-1:0]  s1_idx;

  assign tbl_we    = in_fire && (func_i == FUNC_LOAD);
  assign tbl_wdata = {glyph_code_i, level_a_i, level_b_i, level_c_i, level_d_i};

  ascm_glyph_table u_tbl (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_we),
    .wr_addr_i (table_index_i),
    .wr_data_i (tbl_wdata),
    .rd_en_i   (adv && s1_valid_q),
    .rd_addr_i (s1_idx),
    .rd_data_o (tbl_rdata)
  );

  // error memory, read at acceptance, written from stage two
  lvl4_t   err_rdata;
  err_wr_t err_wr;
  err_wr_t fw_q;

  ascm_err_store u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_addr_i  (ERR_AW'(cell_index_i)),
    .rd_data_o  (err_rdata),
    .wr_i       (err_wr),
    .clearing_o (clearing)
  );

  // stage two: new error is table level minus clamped level, wrapping
  lvl4_t tbl_lvl;
  lvl4_t s2_err;
  assign tbl_lvl = tbl_rdata[31:0];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      s2_err[p] = tbl_lvl[p] - s2_lvl_q[p];
    end
  end

  assign err_wr.en   = adv && s2_valid_q && s2_apply_q;
  assign err_wr.addr = ERR_AW'(s2_cell_q);
  assign err_wr.data = s2_err;

  // stage one: error with forwarding from the write in flight and the
  // write that landed on the same edge as this beat's read
  lvl4_t s1_err;
  lvl4_t s1_lvl;
  logic [ERR_AW-1:0] s1_addr;
  assign s1_addr = ERR_AW'(s1_cell_q);

  always_comb begin
    if (s2_valid_q && s2_apply_q && (ERR_AW'(s2_cell_q) == s1_addr)) begin
      s1_err = s2_err;
    end else if (fw_q.en && (fw_q.addr == s1_addr)) begin
      s1_err = fw_q.data;
    end else begin
      s1_err = err_rdata;
    end
  end

  ascm_quant u_quant (
    .pix_i   (s1_pix_q),
    .err_i   (s1_err),
    .apply_i (s1_apply_q),
    .lvl_o   (s1_lvl),
    .idx_o   (s1_idx)
  );

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      fw_q       <= '0;
    end else if (adv) begin
      s1_valid_q <= conv_fire;
      s2_valid_q <= s1_valid_q;
      fw_q       <= err_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_apply_q  <= dith_q && in_store;
      s1_cell_q   <= cell_index_i;
      s1_pix_q    <= {pixel_tl_i, pixel_tr_i, pixel_bl_i, pixel_br_i};
      s2_apply_q  <= s1_apply_q;
      s2_cell_q   <= s1_cell_q;
      s2_lvl_q    <= s1_lvl;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s2_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_cell_q <= s2_cell_q;
      out_word_q <= {attr_q, tbl_rdata[39:32]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_cell_o  = out_cell_q;
  assign cell_word_o = out_word_q;

  // no beat taken while the error memory is being swept
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_ready_o)
    else $error("beat accepted during error clear");

  // no beat in flight while the sweep owns the write port
  a_pipe_empty_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!s1_valid_q && !s2_valid_q && !err_wr.en))
    else $error("pipeline busy during error clear");

  // a load beat never enters the convert pipeline
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (func_i == FUNC_LOAD)) |=> !s1_valid_q)
    else $error("load beat entered convert pipeline");

  // a finished cell held by a busy output is not lost
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_valid_q && !out_ready_i) |=> (s2_valid_q && $stable(s2_cell_q)))
    else $error("stage two dropped under stall");

  // error write only for a dithered cell leaving stage two
  a_err_wr_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_wr.en |-> (s2_valid_q && s2_apply_q && adv))
    else $error("stray error write");

endmodule

// ----- dv/tb_ascii_cell_mapper_with_temporal_dither_unit.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the ascii cell mapper with its own cell prediction
module tb_ascii_cell_mapper_with_temporal_dither_unit;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 225;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTS     = 40;

  // four levels, element 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
  typedef bit [0:3][7:0] quad_t;

  typedef struct packed {
    logic [13:0] pos;
    logic [15:0] word;
  } cell_word_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ascm_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ascm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  logic                            func;
  logic [15:0]                     table_index;
  logic [7:0]                      glyph_code;
  logic [7:0]                      level_a, level_b, level_c, level_d;
  logic [13:0]                     cell_index;
  logic [7:0]                      pixel_tl, pixel_tr, pixel_bl, pixel_br;
  logic                            out_valid;
  logic                            out_ready;
  logic [13:0]                     out_cell;
  logic [15:0]                     cell_word;

  always #2 clk = ~clk;

  ascii_cell_mapper_with_temporal_dither_unit uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .table_index_i (table_index),
    .glyph_code_i  (glyph_code),
    .level_a_i     (level_a),
    .level_b_i     (level_b),
    .level_c_i     (level_c),
    .level_d_i     (level_d),
    .cell_index_i  (cell_index),
    .pixel_tl_i    (pixel_tl),
    .pixel_tr_i    (pixel_tr),
    .pixel_bl_i    (pixel_bl),
    .pixel_br_i    (pixel_br),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_cell_o    (out_cell),
    .cell_word_o   (cell_word)
  );

  // shadow of the glyph table, the per-cell error store and the registers
  bit [7:0]   glyph_mem    [0:65535];
  quad_t      level_mem    [0:65535];
  bit         entry_loaded [0:65535];
  quad_t      cell_error   [0:ascm_pkg::CELL_COUNT-1];
  bit         dither_on = 1'b0;
  bit [7:0]   attr_byte = ascm_pkg::ATTR_RESET;
  cell_word_t expected_cells [$];

  int unsigned beats_sent     = 0;
  int unsigned loads_sent     = 0;
  int unsigned cells_sent     = 0;
  int unsigned cells_checked  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // pacing knobs shared by the sender, the receiver and the tests
  bit          tx_jitter   = 1'b0;
  bit          rx_jitter   = 1'b0;
  int unsigned rx_hold_cnt = 0;
  int unsigned rx_spell    = 0;

  // ---------------------------------------------------------------- prediction

  // levels as the table lookup sees them, with the stored error added and clamped when dither applies
  function automatic quad_t dithered_levels(logic [13:0] cpos, quad_t pix);
    quad_t             lv;
    int                sum;
    int                p;
    logic signed [7:0] err;
    for (p = 0; p < 4; p++) begin
      sum = pix[p];
      if (dither_on && int'(cpos) < int'(ascm_pkg::CELL_COUNT)) begin
        err = cell_error[cpos][p];
        sum = sum + err;
        if (sum < 0) sum = 0;
        if (sum > int'(ascm_pkg::LVL_MAX)) sum = int'(ascm_pkg::LVL_MAX);
      end
      lv[p] = sum[7:0];
    end
    return lv;
  endfunction

  // top nibbles, top-left most significant
  function automatic logic [15:0] entry_of(quad_t lv);
    return {lv[0][7:4], lv[1][7:4], lv[2][7:4], lv[3][7:4]};
  endfunction

  // predicts one converted cell and folds the new error back into the store
  function automatic cell_word_t convert_cell(logic [13:0] cpos, quad_t pix);
    quad_t       lv;
    logic [15:0] entry;
    cell_word_t  res;
    int          p;
    lv    = dithered_levels(cpos, pix);
    entry = entry_of(lv);
    if (dither_on && int'(cpos) < int'(ascm_pkg::CELL_COUNT))
      for (p = 0; p < 4; p++)
        cell_error[cpos][p] = level_mem[entry][p] - lv[p];
    res.pos  = cpos;
    res.word = {attr_byte, glyph_mem[entry]};
    return res;
  endfunction

  // ---------------------------------------------------------------- random values

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 48);
  endfunction

  // extremes and a few coarse nibbles so that table entries get reused
  function automatic bit [7:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      2, 3, 4: return {4'($urandom_range(0, 3) * 5), 4'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic quad_t rand_quad();
    quad_t q;
    int    p;
    for (p = 0; p < 4; p++) q[p] = rand_level();
    return q;
  endfunction

  // ---------------------------------------------------------------- driving

  // one input beat; valid stays up until the handshake, then an optional gap
  task automatic send_beat(logic f, logic [15:0] tidx, logic [7:0] glyph, quad_t lv,
                           logic [13:0] cpos, quad_t pix, cell_word_t want);
    int unsigned gap;
    in_valid    <= 1'b1;
    func        <= f;
    table_index <= tidx;
    glyph_code  <= glyph;
    level_a     <= lv[0];
    level_b     <= lv[1];
    level_c     <= lv[2];
    level_d     <= lv[3];
    cell_index  <= cpos;
    pixel_tl    <= pix[0];
    pixel_tr    <= pix[1];
    pixel_bl    <= pix[2];
    pixel_br    <= pix[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (f == ascm_pkg::FUNC_CONV) expected_cells.push_back(want);
    if (tx_jitter && $urandom_range(0, 2) == 0) begin
      gap = idle_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(logic [15:0] tidx, logic [7:0] glyph, quad_t lv);
    glyph_mem[tidx]    = glyph;
    level_mem[tidx]    = lv;
    entry_loaded[tidx] = 1'b1;
    loads_sent++;
    send_beat(ascm_pkg::FUNC_LOAD, tidx, glyph, lv, 14'($urandom), quad_t'($urandom), '0);
  endtask

  // a cell never reads an unloaded entry: fill it first with random content
  task automatic send_cell(logic [13:0] cpos, quad_t pix);
    logic [15:0] entry;
    entry = entry_of(dithered_levels(cpos, pix));
    if (!entry_loaded[entry]) send_load(entry, 8'($urandom), quad_t'($urandom));
    cells_sent++;
    send_beat(ascm_pkg::FUNC_CONV, 16'($urandom), 8'($urandom), quad_t'($urandom),
              cpos, pix, convert_cell(cpos, pix));
  endtask

  // rewrites the entry the cell is about to hit, just ahead of it
  task automatic send_cell_with_entry(logic [13:0] cpos, quad_t pix, logic [7:0] glyph,
                                      quad_t lv);
    send_load(entry_of(dithered_levels(cpos, pix)), glyph, lv);
    send_cell(cpos, pix);
  endtask

  // sender pauses until every result is back, then lets a trailing load retire
  task automatic quiesce();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, back to back; upper data bits of the enable are noise
  task automatic set_mode(bit dither, bit [7:0] attr);
    cfg_we    <= 1'b1;
    cfg_idx   <= ascm_pkg::CFG_DITHER;
    cfg_wdata <= {7'($urandom), dither};
    @(posedge clk);
    cfg_idx   <= ascm_pkg::CFG_ATTR;
    cfg_wdata <= attr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    dither_on = dither;
    attr_byte = attr;
  endtask

  // ---------------------------------------------------------------- receiver

  // ready spells and stall spells; a requested hold-off is counted down here
  always @(posedge clk) begin : rx_pacer
    if (rx_hold_cnt != 0) begin
      out_ready <= 1'b0;
      rx_hold_cnt--;
    end else if (!rx_jitter) begin
      out_ready <= 1'b1;
    end else if (rx_spell != 0) begin
      rx_spell--;
    end else begin
      out_ready <= !out_ready;
      rx_spell = out_ready ? idle_len() : $urandom_range(1, 10);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // every result beat is held against the oldest prediction
  always @(posedge clk) begin : result_check
    cell_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        note_mismatch($sformatf("result beat with none awaited: expected nothing, got cell %0d word %h",
                                out_cell, cell_word));
      end else begin
        want = expected_cells.pop_front();
        cells_checked++;
        if (out_cell !== want.pos)
          note_mismatch($sformatf("out_cell: expected %0d, actual %0d", want.pos, out_cell));
        if (cell_word !== want.word)
          note_mismatch($sformatf("cell_word of cell %0d: expected %h, actual %h",
                                  want.pos, want.word, cell_word));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("cycle limit reached with %0d results still awaited", expected_cells.size());
    $display("[ascii_cell_mapper_with_temporal_dither_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // reset values: dither off and attribute 7, no register written yet
  task automatic test_reset_defaults();
    send_load(16'h1234, 8'h2a, {8'h10, 8'h2f, 8'h3c, 8'h40});
    send_cell(14'd100, {8'h10, 8'h20, 8'h30, 8'h40});
    quiesce();
  endtask

  // lowest and highest table entries, cells and attribute
  task automatic test_table_extremes();
    set_mode(1'b0, 8'h00);
    send_load(16'h0000, 8'h00, {4{8'h00}});
    send_load(16'hffff, 8'hff, {4{8'hff}});
    send_cell(14'd0, {4{8'h00}});
    send_cell(14'h3fff, {4{8'hff}});
    quiesce();
    set_mode(1'b0, 8'hff);
    send_cell(14'h3fff, {4{8'h00}});
    send_cell(14'd0, {4{8'hff}});
    quiesce();
  endtask

  // clamp at both ends, largest negative error and a wrapped error
  task automatic test_dither_clamping();
    set_mode(1'b1, 8'hff);
    // errors become +127, +1 (wrapped), 0, -128
    send_cell_with_entry(14'd5, {8'h00, 8'hff, 8'h80, 8'h7f}, 8'h41,
                         {8'h7f, 8'h00, 8'h80, 8'hff});
    // top-left saturates high, bottom-right low
    send_cell_with_entry(14'd5, {8'hc8, 8'h10, 8'h33, 8'h40}, 8'h42,
                         {8'h00, 8'hff, 8'h00, 8'h00});
    send_cell(14'd5, {8'hff, 8'h00, 8'h80, 8'h01});
    quiesce();
  endtask

  // with dither off the store is neither read nor written, so it survives
  task automatic test_dither_bypass();
    set_mode(1'b0, 8'h3c);
    send_cell(14'd5, {4{8'h80}});
    quiesce();
    set_mode(1'b1, 8'hc3);
    send_cell(14'd5, {4{8'h80}});
    quiesce();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_hold_off();
    int unsigned i;
    tx_jitter   = 1'b0;
    rx_jitter   = 1'b1;
    rx_hold_cnt = HOLD_OFF_CYCLES;
    for (i = 0; i < 48; i++) send_cell(14'($urandom_range(0, 3)), rand_quad());
    quiesce();
  endtask

  // phases of mixed loads and cells, mostly on a few hot cells and in bursts
  task automatic test_random_traffic();
    logic [13:0] pool [6];
    logic [13:0] cpos;
    int unsigned ph;
    int unsigned start;
    int unsigned burst;
    pool = '{14'd0, 14'h3fff, 14'd5, 14'($urandom), 14'($urandom), 14'($urandom)};
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiesce();
      set_mode(ph % 4 != 2, (ph == 0) ? 8'h00 : (ph == 1) ? 8'hff : 8'($urandom));
      tx_jitter = (ph % 3 != 1) && (ph != RANDOM_PHASES - 1);
      rx_jitter = (ph % 3 != 0) && (ph != RANDOM_PHASES - 1);
      start = beats_sent;
      while (beats_sent - start < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 19) < 3) begin
          send_load(16'($urandom), 8'($urandom), quad_t'($urandom));
        end else begin
          cpos  = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 5)] : 14'($urandom);
          burst = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : 1;
          repeat (burst) begin
            if ($urandom_range(0, 9) == 0)
              send_cell_with_entry(cpos, rand_quad(), 8'($urandom), quad_t'($urandom));
            else
              send_cell(cpos, rand_quad());
          end
        end
      end
    end
    quiesce();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : run
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= ascm_pkg::CFG_DITHER;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    func        <= ascm_pkg::FUNC_LOAD;
    table_index <= '0;
    glyph_code  <= '0;
    level_a     <= '0;
    level_b     <= '0;
    level_c     <= '0;
    level_d     <= '0;
    cell_index  <= '0;
    pixel_tl    <= '0;
    pixel_tr    <= '0;
    pixel_bl    <= '0;
    pixel_br    <= '0;
    out_ready   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the first beat also waits out the error store sweep after reset
    test_reset_defaults();
    test_table_extremes();
    test_dither_clamping();
    test_dither_bypass();
    test_output_hold_off();
    test_random_traffic();

    $display("%0d beats sent: %0d table loads, %0d cells; %0d cell results checked",
             beats_sent, loads_sent, cells_sent, cells_checked);
    $display("dither on and off, attribute extremes, error clamping and wrap, output hold-off");
    if (mismatch_count == 0)
      $display("[ascii_cell_mapper_with_temporal_dither_unit] OK");
    else
      $display("[ascii_cell_mapper_with_temporal_dither_unit] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ascm_pkg.sv
rtl/ascm_err_store.sv
rtl/ascm_glyph_table.sv
rtl/ascm_quant.sv
rtl/ascii_cell_mapper_with_temporal_dither_unit.sv
dv/tb_ascii_cell_mapper_with_temporal_dither_unit.sv
